FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the arithmetic encoder.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");

// Consequence holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Consequence holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: rtl/arenc_pkg.sv
// Package of the arithmetic encoder: widths, status and function codes, sequencer states.
// Depends on nothing; imported by arithmetic_encoder_16bit.
package arenc_pkg;

	// Default coder width and fixed field widths.
	localparam int CODE_BITS_DEF = 16;
	localparam int TOTAL_W       = 14;
	localparam int PEND_W        = 16;
	localparam int S_TDATA_W     = 48;
	localparam int M_TDATA_W     = 24;
	localparam int MAX_RESULTS   = 16;

	localparam logic [TOTAL_W-1:0] MAX_TOTAL_RESET = 14'd16383;

	// Function codes carried on the input side band.
	localparam logic FUNC_ENCODE = 1'b0;
	localparam logic FUNC_FLUSH  = 1'b1;

	// Result status codes.
	typedef enum logic [1:0] {
		STAT_OK  = 2'd0,
		STAT_BAD = 2'd1,
		STAT_SAT = 2'd2
	} status_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_A,
		ST_DIV_A,
		ST_MUL_B,
		ST_DIV_B,
		ST_UPDATE,
		ST_RENORM,
		ST_FINAL
	} state_t;

endpackage

FILE: rtl/arithmetic_encoder_16bit.sv
// Integer arithmetic encoder for a three-symbol alphabet with follow-bit counting.
// Depends on arenc_pkg and assert_macros.svh.
`include "assert_macros.svh"

// An encode word passes from acceptance through ST_MUL_A, ST_DIV_A, ST_MUL_B, ST_DIV_B,
// ST_UPDATE and ST_RENORM to its last result in ST_FINAL. One shared restoring divider
// produces one quotient bit per cycle for each of the two interval bounds, and the
// renormalizer then makes one shift per cycle while it is not stalled. Flush words and
// tables rejected on their entries alone go from ST_IDLE straight to ST_FINAL; a slice
// that maps to an empty interval is only found after both divisions. The input is not
// ready while a word is being worked on; a result may wait in the output register while
// the next input word is taken, and the renormalizer stalls only when a new bit is ready
// while a bit is held and the output register still holds a result not yet taken.
module arithmetic_encoder_16bit #(
	parameter int CODE_BITS = arenc_pkg::CODE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [arenc_pkg::TOTAL_W-1:0]    cfg_wr_data,   // max_total
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// symbol[1:0], cum_total[15:2], cum_one[29:16], cum_two[43:30], zero fill
	input  logic [arenc_pkg::S_TDATA_W-1:0]  s_tdata,
	input  logic [0:0]                       s_tuser,       // func
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// code_bit[0], follow_count[16:1], status[18:17], zero fill
	output logic [arenc_pkg::M_TDATA_W-1:0]  m_tdata,
	output logic [0:0]                       m_tuser,       // has_bit
	output logic                             m_tlast        // last
);
	import arenc_pkg::*;

	localparam int QW        = CODE_BITS + 1;
	localparam int PW        = QW + TOTAL_W;
	localparam int CNT_W     = $clog2(QW);
	localparam int RES_CNT_W = $clog2(MAX_RESULTS + 1);

	localparam logic [CODE_BITS-1:0] HALF = {1'b1, {(CODE_BITS-1){1'b0}}};
	localparam logic [CODE_BITS-1:0] QTR1 = {2'b01, {(CODE_BITS-2){1'b0}}};
	localparam logic [CODE_BITS-1:0] QTR3 = {2'b11, {(CODE_BITS-2){1'b0}}};

	state_t state_q, state_n;

	// Coder state and configuration.
	logic [TOTAL_W-1:0]   max_total_q;
	logic [CODE_BITS-1:0] low_q, high_q;
	logic [PEND_W-1:0]    pending_q;
	logic                 sat_q;

	// Captured table operands.
	logic [TOTAL_W-1:0] tot_q, cp_q, cc_q;

	// Shared multiply / divide unit.
	logic [TOTAL_W-1:0] rem_q;
	logic [QW-1:0]      quo_q, a_q;
	logic [CNT_W-1:0]   cnt_q;

	// Held result (one behind, so the final one can be marked last).
	logic               hold_vld_q, hold_has_q, hold_bit_q, hold_bad_q;
	logic [PEND_W-1:0]  hold_follow_q;
	logic [RES_CNT_W-1:0] res_cnt_q;

	// Output register.
	logic               m_tvalid_q, out_has_q, out_bit_q, out_last_q;
	logic [PEND_W-1:0]  out_follow_q;
	status_t            out_status_q;

	// Input word unpacking.
	logic                 in_func;
	logic [1:0]           in_sym;
	logic [TOTAL_W-1:0]   in_tot, in_one, in_two, in_cp, in_cc;
	logic                 in_acc, in_err, in_flush, out_free;

	assign in_func  = s_tuser[0];
	assign in_sym   = s_tdata[1:0];
	assign in_tot   = s_tdata[15:2];
	assign in_one   = s_tdata[29:16];
	assign in_two   = s_tdata[43:30];
	assign in_acc   = s_tvalid && s_tready;
	assign in_flush = (in_func == FUNC_FLUSH);
	assign out_free = !m_tvalid_q || m_tready;

	// Select the symbol's slice of the cumulative table.
	always_comb begin
		case (in_sym)
			2'd1: begin
				in_cp = in_tot;
				in_cc = in_one;
			end
			2'd2: begin
				in_cp = in_one;
				in_cc = in_two;
			end
			2'd3: begin
				in_cp = in_two;
				in_cc = '0;
			end
			default: begin
				in_cp = '0;
				in_cc = '0;
			end
		endcase
	end

	// A slice whose lower entry is not below its upper entry always maps to an empty
	// interval, so it is rejected together with the other table faults.
	assign in_err = (in_sym == 2'd0) || (in_tot == '0) || (in_tot > max_total_q) ||
			(in_cp > in_tot) || (in_cc >= in_cp);

	// Shared multiplier: range times the selected cumulative entry.
	logic [QW-1:0]      range_w;
	logic [TOTAL_W-1:0] mul_op;
	logic [PW-1:0]      prod;

	assign range_w = {1'b0, high_q} - {1'b0, low_q} + QW'(1);
	assign mul_op  = (state_q == ST_MUL_A) ? cp_q : cc_q;
	assign prod    = PW'(range_w) * PW'(mul_op);

	// Restoring divider step, one quotient bit per cycle.
	logic [TOTAL_W:0] div_t, div_diff;
	logic             div_ge;

	assign div_t    = {rem_q, quo_q[QW-1]};
	assign div_ge   = div_t >= {1'b0, tot_q};
	assign div_diff = div_t - {1'b0, tot_q};

	// Interval update from the two quotients.
	logic          upd_bad;
	logic [QW-1:0] upd_high, upd_low;

	assign upd_bad  = a_q <= quo_q;
	assign upd_high = {1'b0, low_q} + a_q - QW'(1);
	assign upd_low  = {1'b0, low_q} + quo_q;

	// Renormalization decision and shift.
	logic                 ren_e0, ren_e1, ren_mid, ren_emit, ren_done;
	logic                 res_room, ren_push, ren_stall;
	logic [CODE_BITS-1:0] ren_sub, low_sub, high_sub, low_nx, high_nx;

	assign ren_e0    = high_q < HALF;
	assign ren_e1    = !ren_e0 && (low_q >= HALF);
	assign ren_mid   = !ren_e0 && !ren_e1 && (low_q >= QTR1) && (high_q < QTR3);
	assign ren_emit  = ren_e0 || ren_e1;
	assign ren_done  = !ren_emit && !ren_mid;
	assign ren_sub   = ren_e1 ? HALF : (ren_mid ? QTR1 : '0);
	assign low_sub   = low_q - ren_sub;
	assign high_sub  = high_q - ren_sub;
	assign low_nx    = {low_sub[CODE_BITS-2:0], 1'b0};
	assign high_nx   = {high_sub[CODE_BITS-2:0], 1'b1};
	assign res_room  = res_cnt_q < RES_CNT_W'(MAX_RESULTS);
	assign ren_push  = ren_emit && hold_vld_q && res_room;
	assign ren_stall = ren_push && !out_free;

	// Flush: the final bit picks the quarter that low sits in.
	logic              fl_sat, fl_bit;
	logic [PEND_W-1:0] fl_follow;

	assign fl_sat    = (pending_q == '1);
	assign fl_follow = fl_sat ? pending_q : pending_q + PEND_W'(1);
	assign fl_bit    = low_q >= QTR1;

	// Status of a pushed result.
	status_t mid_status, fin_status;

	assign mid_status = sat_q ? STAT_SAT : STAT_OK;
	assign fin_status = (hold_vld_q && hold_bad_q) ? STAT_BAD : mid_status;

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// Sequencer next state and handshake.
	always_comb begin
		state_n  = state_q;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (in_acc) begin
					state_n = (in_flush || in_err) ? ST_FINAL : ST_MUL_A;
				end
			end
			ST_MUL_A: begin
				state_n = ST_DIV_A;
			end
			ST_DIV_A: begin
				if (cnt_q == '0) begin
					state_n = ST_MUL_B;
				end
			end
			ST_MUL_B: begin
				state_n = ST_DIV_B;
			end
			ST_DIV_B: begin
				if (cnt_q == '0) begin
					state_n = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				state_n = upd_bad ? ST_FINAL : ST_RENORM;
			end
			ST_RENORM: begin
				if (ren_done) begin
					state_n = ST_FINAL;
				end
			end
			ST_FINAL: begin
				if (out_free) begin
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	// Coder state, configuration and result control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_total_q <= MAX_TOTAL_RESET;
			low_q       <= '0;
			high_q      <= '1;
			pending_q   <= '0;
			sat_q       <= 1'b0;
			hold_vld_q  <= 1'b0;
			res_cnt_q   <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				max_total_q <= cfg_wr_data;
			end
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						sat_q      <= 1'b0;
						hold_vld_q <= 1'b0;
						res_cnt_q  <= '0;
						if (in_flush) begin
							sat_q      <= fl_sat;
							hold_vld_q <= 1'b1;
							res_cnt_q  <= RES_CNT_W'(1);
							low_q      <= '0;
							high_q     <= '1;
							pending_q  <= '0;
						end else if (in_err) begin
							hold_vld_q <= 1'b1;
							res_cnt_q  <= RES_CNT_W'(1);
						end
					end
				end
				ST_UPDATE: begin
					if (upd_bad) begin
						hold_vld_q <= 1'b1;
						res_cnt_q  <= RES_CNT_W'(1);
					end else begin
						high_q <= upd_high[CODE_BITS-1:0];
						low_q  <= upd_low[CODE_BITS-1:0];
					end
				end
				ST_RENORM: begin
					if (!ren_done && !ren_stall) begin
						low_q  <= low_nx;
						high_q <= high_nx;
						if (ren_mid) begin
							if (pending_q == '1) begin
								sat_q <= 1'b1;
							end else begin
								pending_q <= pending_q + PEND_W'(1);
							end
						end else begin
							pending_q <= '0;
							if (res_room) begin
								hold_vld_q <= 1'b1;
								res_cnt_q  <= res_cnt_q + RES_CNT_W'(1);
								if (hold_vld_q) begin
									m_tvalid_q <= 1'b1;
								end
							end
						end
					end
				end
				ST_FINAL: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						hold_vld_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Operands, divider, held result and output payload.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					tot_q <= in_tot;
					cp_q  <= in_cp;
					cc_q  <= in_cc;
					if (in_flush) begin
						hold_has_q    <= 1'b1;
						hold_bit_q    <= fl_bit;
						hold_follow_q <= fl_follow;
						hold_bad_q    <= 1'b0;
					end else begin
						hold_has_q    <= 1'b0;
						hold_bit_q    <= 1'b0;
						hold_follow_q <= '0;
						hold_bad_q    <= 1'b1;
					end
				end
			end
			ST_MUL_A, ST_MUL_B: begin
				rem_q <= prod[PW-1:QW];
				quo_q <= prod[QW-1:0];
				cnt_q <= CNT_W'(QW - 1);
				if (state_q == ST_MUL_B) begin
					a_q <= quo_q;
				end
			end
			ST_DIV_A, ST_DIV_B: begin
				rem_q <= div_ge ? div_diff[TOTAL_W-1:0] : div_t[TOTAL_W-1:0];
				quo_q <= {quo_q[QW-2:0], div_ge};
				cnt_q <= cnt_q - CNT_W'(1);
			end
			ST_UPDATE: begin
				hold_has_q    <= 1'b0;
				hold_bit_q    <= 1'b0;
				hold_follow_q <= '0;
				hold_bad_q    <= 1'b1;
			end
			ST_RENORM: begin
				if (ren_emit && !ren_stall && res_room) begin
					if (hold_vld_q) begin
						out_has_q    <= hold_has_q;
						out_bit_q    <= hold_bit_q;
						out_follow_q <= hold_follow_q;
						out_last_q   <= 1'b0;
						out_status_q <= mid_status;
					end
					hold_has_q    <= 1'b1;
					hold_bit_q    <= ren_e1;
					hold_follow_q <= pending_q;
					hold_bad_q    <= 1'b0;
				end
			end
			ST_FINAL: begin
				if (out_free) begin
					out_last_q   <= 1'b1;
					out_status_q <= fin_status;
					if (hold_vld_q) begin
						out_has_q    <= hold_has_q;
						out_bit_q    <= hold_bit_q;
						out_follow_q <= hold_follow_q;
					end else begin
						out_has_q    <= 1'b0;
						out_bit_q    <= 1'b0;
						out_follow_q <= '0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Output packing.
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(M_TDATA_W - PEND_W - 3){1'b0}}, out_status_q, out_follow_q, out_bit_q};
	assign m_tuser  = out_has_q;
	assign m_tlast  = out_last_q;

	// The interval never inverts.
	`ASSERT_ALWAYS(a_interval_order, clk, arst_n, low_q <= high_q)
	// No more results per word than the limit.
	`ASSERT_ALWAYS(a_result_limit, clk, arst_n, res_cnt_q <= RES_CNT_W'(MAX_RESULTS))
	// The divider remainder stays below the total while it runs.
	`ASSERT_IMPLY(a_div_rem, clk, arst_n, state_q == ST_DIV_A || state_q == ST_DIV_B, rem_q < tot_q)
	// A result without a code bit is always the last of its word.
	`ASSERT_IMPLY(a_nobit_last, clk, arst_n, m_tvalid && !m_tuser[0], m_tlast)
	// A rejected table goes straight to the final result.
	`ASSERT_NEXT(a_err_final, clk, arst_n, in_acc && !in_flush && in_err, state_q == ST_FINAL)

endmodule

FILE: sim/arithmetic_encoder_16bit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of arithmetic_encoder_16bit: streams encode and flush words,
// predicts every result word with its own interval coder and compares field by field.
// Depends on arenc_pkg and the encoder RTL.
module arithmetic_encoder_16bit_tb;
	import arenc_pkg::*;

	localparam longint unsigned CODE_TOP  = 65535;
	localparam longint unsigned CODE_QTR  = 16384;
	localparam longint unsigned CODE_HALF = 32768;
	localparam longint unsigned CODE_3QTR = 49152;
	localparam int TOTAL_FULL  = 16383;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int PRINT_LIMIT = 100;

	// One input word as the coder sees it.
	typedef struct packed {
		logic               func;
		logic [1:0]         symbol;
		logic [TOTAL_W-1:0] total;
		logic [TOTAL_W-1:0] cum_one;
		logic [TOTAL_W-1:0] cum_two;
	} enc_word_t;

	// One result word.
	typedef struct packed {
		logic        has_bit;
		logic        code_bit;
		logic [15:0] follow;
		logic        last;
		status_t     status;
	} code_res_t;

	// Interval and follow-bit count of the coder.
	typedef struct packed {
		logic [15:0] low;
		logic [15:0] high;
		logic [15:0] pend;
	} coder_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [TOTAL_W-1:0]   cfg_wr_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic [0:0]           s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [0:0]           m_tuser;
	logic                 m_tlast;

	enc_word_t          words_to_send [$];
	code_res_t          expected_codes [$];
	enc_word_t          driven_word;
	code_res_t          want;
	coder_t             chk_state;
	coder_t             gen_state;
	logic [TOTAL_W-1:0] max_total_cfg;
	code_res_t          word_res [MAX_RESULTS];
	int                 word_nres;
	int                 tx_idle_pct;
	int                 rx_idle_pct;
	int                 mismatch_count = 0;
	int                 cycle_count = 0;

	arithmetic_encoder_16bit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast)
	);

	// Clock of 10 ns.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Append one result word; words beyond the result limit are dropped.
	function automatic void add_result(input logic has, input logic bitv,
			input logic [15:0] follow);
		if (word_nres < MAX_RESULTS) begin
			word_res[word_nres].has_bit  = has;
			word_res[word_nres].code_bit = bitv;
			word_res[word_nres].follow   = follow;
			word_res[word_nres].last     = 1'b0;
			word_res[word_nres].status   = STAT_OK;
			word_nres++;
		end
	endfunction

	// Coder step: returns the next state and leaves the result words in word_res.
	function automatic coder_t encode_word(input coder_t st, input logic [TOTAL_W-1:0] limit,
			input enc_word_t w);
		coder_t nx;
		longint unsigned lo, hi, tot, cp, cc, span, a, b;
		logic sat, bad, go;
		nx = st;
		sat = 1'b0;
		word_nres = 0;
		if (w.func == FUNC_FLUSH) begin
			// The closing bit picks the quarter holding low and owes one more follow bit.
			if (nx.pend == 16'hFFFF) sat = 1'b1;
			else nx.pend = nx.pend + 16'd1;
			add_result(1'b1, (longint'(st.low) < CODE_QTR) ? 1'b0 : 1'b1, nx.pend);
			nx.low  = '0;
			nx.high = 16'hFFFF;
			nx.pend = '0;
		end else begin
			tot = w.total;
			case (w.symbol)
			2'd1: begin
				cp = w.total;
				cc = w.cum_one;
			end
			2'd2: begin
				cp = w.cum_one;
				cc = w.cum_two;
			end
			2'd3: begin
				cp = w.cum_two;
				cc = 0;
			end
			default: begin
				cp = 0;
				cc = 0;
			end
			endcase
			lo = st.low;
			hi = st.high;
			a = 0;
			b = 0;
			bad = (w.symbol == 2'd0) || (w.total == '0) || (w.total > limit);
			if (!bad) begin
				span = hi - lo + 1;
				a = (span * cp) / tot;
				b = (span * cc) / tot;
				bad = (cp > tot) || (a <= b);
			end
			// A rejected table gives one flagged word and keeps the state.
			if (bad) begin
				add_result(1'b0, 1'b0, 16'd0);
				word_res[0].status = STAT_BAD;
				word_res[0].last   = 1'b1;
				return st;
			end
			hi = lo + a - 1;
			lo = lo + b;
			// Renormalize until the interval straddles the half point widely enough.
			go = 1'b1;
			while (go) begin
				if (hi < CODE_HALF) begin
					add_result(1'b1, 1'b0, nx.pend);
					nx.pend = '0;
				end else if (lo >= CODE_HALF) begin
					add_result(1'b1, 1'b1, nx.pend);
					nx.pend = '0;
					lo = lo - CODE_HALF;
					hi = hi - CODE_HALF;
				end else if (lo >= CODE_QTR && hi < CODE_3QTR) begin
					if (nx.pend == 16'hFFFF) sat = 1'b1;
					else nx.pend = nx.pend + 16'd1;
					lo = lo - CODE_QTR;
					hi = hi - CODE_QTR;
				end else begin
					go = 1'b0;
				end
				if (go) begin
					lo = (2 * lo) & CODE_TOP;
					hi = (2 * hi + 1) & CODE_TOP;
				end
			end
			nx.low  = lo[15:0];
			nx.high = hi[15:0];
		end
		if (word_nres == 0) add_result(1'b0, 1'b0, 16'd0);
		for (int k = 0; k < word_nres; k++) word_res[k].status = sat ? STAT_SAT : STAT_OK;
		word_res[word_nres-1].last = 1'b1;
		return nx;
	endfunction

	function automatic enc_word_t make_word(input int func, input int sym, input int tot,
			input int one, input int two);
		enc_word_t w;
		w.func    = 1'(func);
		w.symbol  = 2'(sym);
		w.total   = TOTAL_W'(tot);
		w.cum_one = TOTAL_W'(one);
		w.cum_two = TOTAL_W'(two);
		return w;
	endfunction

	// Queue a word and track the state the coder will be in after it.
	task automatic queue_word(input enc_word_t w);
		gen_state = encode_word(gen_state, max_total_cfg, w);
		words_to_send.push_back(w);
	endtask

	// Random words: mostly valid tables, some flushes, some broken or raw tables.
	task automatic queue_random(input int n);
		enc_word_t w;
		int pick, cap;
		repeat (n) begin
			pick = $urandom_range(99);
			w = make_word(int'(FUNC_ENCODE), $urandom, $urandom, $urandom, $urandom);
			if (pick < 9) begin
				w.func = FUNC_FLUSH;
			end else if (pick < 21) begin
				case ($urandom_range(5))
				0: w.symbol = 2'd0;
				1: w.total = '0;
				2: begin
					if (int'(max_total_cfg) < TOTAL_FULL)
						w.total = TOTAL_W'($urandom_range(TOTAL_FULL, int'(max_total_cfg) + 1));
				end
				3: begin
					w.symbol = 2'd2;
					if (int'(w.total) < TOTAL_FULL)
						w.cum_one = TOTAL_W'($urandom_range(TOTAL_FULL, int'(w.total) + 1));
				end
				4: begin
					w.symbol  = 2'd2;
					w.cum_two = w.cum_one;
				end
				default: ;
				endcase
			end else begin
				cap = ($urandom_range(1) == 0 && max_total_cfg > 64) ? 64 : int'(max_total_cfg);
				w.total   = TOTAL_W'($urandom_range(cap, 1));
				w.cum_one = TOTAL_W'($urandom_range(int'(w.total), 0));
				w.cum_two = TOTAL_W'($urandom_range(int'(w.cum_one), 0));
				w.symbol  = 2'($urandom_range(3, 1));
			end
			queue_word(w);
		end
	endtask

	// Wait until every queued word is taken and every expected result has come.
	task automatic drain_results();
		@(posedge clk);
		while (words_to_send.size() != 0 || s_tvalid || expected_codes.size() != 0)
			@(posedge clk);
	endtask

	// Change max_total while the coder is idle.
	task automatic write_max_total(input int value);
		drain_results();
		cfg_wr_en     <= 1'b1;
		cfg_wr_data   <= TOTAL_W'(value);
		max_total_cfg = TOTAL_W'(value);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic report_mismatch(input string msg);
		if (mismatch_count < PRINT_LIMIT)
			$display("mismatch at cycle %0d: %s", cycle_count, msg);
		mismatch_count++;
	endtask

	// Stimulus sequence.
	initial begin
		longint unsigned lo_v, hi_v, span, mid;
		int steps;
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = '0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = '0;
		m_tready      = 1'b0;
		max_total_cfg = MAX_TOTAL_RESET;
		chk_state     = '{low: 16'd0, high: 16'hFFFF, pend: 16'd0};
		gen_state     = chk_state;
		tx_idle_pct   = 21;
		rx_idle_pct   = 60;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed words under the reset value of max_total.
		queue_word(make_word(FUNC_ENCODE, 1, TOTAL_FULL, 0, 0));
		queue_word(make_word(FUNC_ENCODE, 3, TOTAL_FULL, TOTAL_FULL, 1));
		queue_word(make_word(FUNC_ENCODE, 1, TOTAL_FULL, 16382, 0));
		queue_word(make_word(FUNC_ENCODE, 2, TOTAL_FULL, 8192, 8191));
		queue_word(make_word(FUNC_ENCODE, 2, TOTAL_FULL, 8192, 8191));
		queue_word(make_word(FUNC_ENCODE, 3, TOTAL_FULL, TOTAL_FULL, 1));
		queue_word(make_word(FUNC_FLUSH, 0, 0, 0, 0));
		queue_word(make_word(FUNC_ENCODE, 2, TOTAL_FULL, 8192, 8191));
		queue_word(make_word(FUNC_FLUSH, 3, TOTAL_FULL, TOTAL_FULL, TOTAL_FULL));
		queue_word(make_word(FUNC_ENCODE, 2, 0, 0, 0));
		queue_word(make_word(FUNC_ENCODE, 0, 100, 50, 20));
		queue_word(make_word(FUNC_ENCODE, 2, 50, 100, 10));
		queue_word(make_word(FUNC_ENCODE, 2, 10, 5, 5));
		queue_word(make_word(FUNC_ENCODE, 3, TOTAL_FULL, TOTAL_FULL, 0));
		queue_word(make_word(FUNC_ENCODE, 1, 100, 200, 0));
		queue_word(make_word(FUNC_ENCODE, 1, TOTAL_FULL, TOTAL_FULL, 0));
		queue_word(make_word(FUNC_ENCODE, 1, 1, 0, 0));
		queue_word(make_word(FUNC_ENCODE, 3, TOTAL_FULL, TOTAL_FULL, TOTAL_FULL));
		queue_word(make_word(FUNC_ENCODE, 2, 3, 2, 1));
		queue_word(make_word(FUNC_FLUSH, 0, 0, 0, 0));

		// Smallest limit: only a total of one gets through.
		write_max_total(1);
		queue_word(make_word(FUNC_ENCODE, 1, 1, 0, 0));
		queue_word(make_word(FUNC_ENCODE, 2, 1, 1, 0));
		queue_word(make_word(FUNC_ENCODE, 3, 1, 1, 1));
		queue_word(make_word(FUNC_ENCODE, 1, 2, 0, 0));
		queue_word(make_word(FUNC_ENCODE, 3, TOTAL_FULL, 1, 0));
		queue_random(25);

		// Mid-range limit, with a full pause of the sender halfway.
		write_max_total($urandom_range(2000, 200));
		queue_random(60);
		drain_results();
		queue_random(60);

		// Largest limit, idling the other way round.
		write_max_total(TOTAL_FULL);
		tx_idle_pct = 60;
		rx_idle_pct = 21;
		queue_random(150);

		// High random limit, no idling.
		write_max_total($urandom_range(TOTAL_FULL - 1, 8000));
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		queue_random(100);

		// Long follow-bit runs: every word narrows onto the half point, so no bit
		// settles and the count keeps growing until the closing flush.
		write_max_total(TOTAL_FULL);
		queue_word(make_word(FUNC_FLUSH, 0, 0, 0, 0));
		steps = 0;
		while (steps < 20) begin
			lo_v = gen_state.low;
			hi_v = gen_state.high;
			span = hi_v - lo_v + 1;
			mid  = CODE_HALF - lo_v;
			queue_word(make_word(FUNC_ENCODE, 2, TOTAL_FULL,
				int'(((mid + 1) * TOTAL_FULL + span - 1) / span),
				int'(((mid - 1) * TOTAL_FULL) / span)));
			steps++;
		end
		queue_word(make_word(FUNC_FLUSH, 0, 0, 0, 0));

		drain_results();
		repeat (60) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Driver: predict each word as it is taken and offer the next one.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				chk_state = encode_word(chk_state, max_total_cfg, driven_word);
				for (int k = 0; k < word_nres; k++) expected_codes.push_back(word_res[k]);
			end
			if (!s_tvalid || s_tready) begin
				if (words_to_send.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					driven_word = words_to_send.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {4'b0, driven_word.cum_two, driven_word.cum_one,
						driven_word.total, driven_word.symbol};
					s_tuser  <= driven_word.func;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each taken result word with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_codes.size() == 0) begin
					report_mismatch("result word with nothing expected");
				end else begin
					want = expected_codes.pop_front();
					if (m_tuser[0] !== want.has_bit)
						report_mismatch($sformatf("has_bit %b, expected %b", m_tuser[0],
							want.has_bit));
					if (m_tdata[0] !== want.code_bit)
						report_mismatch($sformatf("code_bit %b, expected %b", m_tdata[0],
							want.code_bit));
					if (m_tdata[16:1] !== want.follow)
						report_mismatch($sformatf("follow_count %0d, expected %0d",
							m_tdata[16:1], want.follow));
					if (m_tlast !== want.last)
						report_mismatch($sformatf("last %b, expected %b", m_tlast, want.last));
					if (m_tdata[18:17] !== want.status)
						report_mismatch($sformatf("status %0d, expected %0d", m_tdata[18:17],
							want.status));
				end
			end
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Watchdog on the length of the run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

endmodule
